@@ rtl/core/htok_pkg.sv @@
package htok_pkg;

	// One input byte of the HTTP stream
	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} req_t;

	// One tagged token
	typedef struct packed {
		logic [2:0] field_kind;
		logic       has_char;
		logic [7:0] char_out;
		logic       field_end;
		logic       request_end;
	} tok_t;

	// Tokens produced by one byte, at most three
	localparam int unsigned STEP_MAX = 3;

	typedef struct packed {
		logic [1:0]         cnt;
		tok_t [STEP_MAX-1:0] ent;
	} step_t;

	typedef enum logic [3:0] {
		PH_VERB  = 4'd0,
		PH_GAP   = 4'd1,
		PH_PATH  = 4'd2,
		PH_QKEY  = 4'd3,
		PH_QVAL  = 4'd4,
		PH_PROTO = 4'd5,
		PH_HKEY  = 4'd6,
		PH_HGAP  = 4'd7,
		PH_HVAL  = 4'd8,
		PH_HEOL  = 4'd9,
		PH_HEND  = 4'd10,
		PH_BODY  = 4'd11
	} phase_t;

	localparam logic [2:0] KIND_VERB  = 3'd0;
	localparam logic [2:0] KIND_PATH  = 3'd1;
	localparam logic [2:0] KIND_QKEY  = 3'd2;
	localparam logic [2:0] KIND_QVAL  = 3'd3;
	localparam logic [2:0] KIND_PROTO = 3'd4;
	localparam logic [2:0] KIND_HKEY  = 3'd5;
	localparam logic [2:0] KIND_HVAL  = 3'd6;
	localparam logic [2:0] KIND_BODY  = 3'd7;

	localparam logic [1:0] ESC_IDLE = 2'd0;
	localparam logic [1:0] ESC_HI   = 2'd1;
	localparam logic [1:0] ESC_LO   = 2'd2;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;

endpackage

@@ rtl/core/htok_parser.sv @@
module htok_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  htok_pkg::req_t req,
	input  logic          adv,
	output htok_pkg::step_t step
);
	import htok_pkg::*;

	phase_t     phase_q;
	logic [1:0] esc_q;
	logic [7:0] held_q;
	logic       ls_q;

	phase_t     ph;
	logic [1:0] esc;
	logic [7:0] held;
	logic       ls;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic logic [4:0] hex_val(input logic [7:0] d);
		// bit 4: digit is valid
		logic [7:0] v;
		v = 8'd0;
		if (d >= 8'h61 && d <= 8'h66) v = d - 8'h57;
		else if (d >= 8'h41 && d <= 8'h46) v = d - 8'h37;
		else if (d >= 8'h30 && d <= 8'h39) v = d - 8'h30;
		return {(d >= 8'h61 && d <= 8'h66) || (d >= 8'h41 && d <= 8'h46) ||
			(d >= 8'h30 && d <= 8'h39), v[3:0]};
	endfunction

	function automatic logic [7:0] decode_pair(input logic [7:0] hi, input logic [7:0] lo);
		logic [4:0] h;
		logic [4:0] l;
		logic [7:0] acc;
		h = hex_val(hi);
		l = hex_val(lo);
		acc = h[4] ? {h[3:0], 4'd0} : CH_QUEST;
		if (l[4]) acc = acc + {4'd0, l[3:0]};
		return acc;
	endfunction

	function automatic tok_t mk(input logic [2:0] k, input logic has, input logic [7:0] ch,
		input logic fe);
		tok_t t;
		t.field_kind  = k;
		t.has_char    = has;
		t.char_out    = ch;
		t.field_end   = fe;
		t.request_end = 1'b0;
		return t;
	endfunction

	always_comb begin
		logic [7:0] b;
		logic       last;
		logic       bws;
		logic       crlf;
		logic       stop;
		logic       done;
		logic [2:0] k;
		logic       fin_open;
		logic [2:0] fin_kind;
		logic [1:0] n;
		tok_t       t;
		b        = req.byte_in;
		last     = req.last_byte;
		bws      = is_ws(b);
		crlf     = (b == CH_CR) || (b == CH_LF);
		ph       = phase_q;
		esc      = esc_q;
		held     = held_q;
		ls       = ls_q;
		stop     = 1'b0;
		done     = 1'b0;
		k        = KIND_VERB;
		n        = 2'd0;
		step     = '0;
		fin_open = 1'b1;
		fin_kind = KIND_VERB;
		t        = '0;

		// skip / hand-over phases
		case (ph)
			PH_GAP: begin
				if (bws) stop = 1'b1;
				else ph = PH_PATH;
			end
			PH_HGAP: begin
				if (bws) stop = 1'b1;
				else ph = PH_HVAL;
			end
			PH_HEOL: begin
				ph = PH_HKEY;
				ls = 1'b1;
				if (b == CH_LF) stop = 1'b1;
			end
			PH_HEND: begin
				if (crlf) stop = 1'b1;
				else ph = PH_BODY;
			end
			default: ;
		endcase

		if (!stop) begin
			case (ph)
				PH_PATH, PH_QKEY, PH_QVAL: begin
					k = (ph == PH_PATH) ? KIND_PATH :
						(ph == PH_QKEY) ? KIND_QKEY : KIND_QVAL;
					if (esc == ESC_HI) begin
						if (!last) begin
							held = b;
							esc  = ESC_LO;
							done = 1'b1;
						end else begin
							// escape cut off: literal '%'
							step.ent[n] = mk(k, 1'b1, CH_PCT, 1'b0);
							n = n + 2'd1;
							esc = ESC_IDLE;
						end
					end else if (esc != ESC_IDLE) begin
						step.ent[n] = mk(k, 1'b1, decode_pair(held_q, b), 1'b0);
						n = n + 2'd1;
						esc  = ESC_IDLE;
						done = 1'b1;
					end
					if (!done) begin
						if (bws) begin
							step.ent[n] = mk(k, 1'b0, 8'd0, 1'b1);
							n = n + 2'd1;
							ph = PH_PROTO;
						end else if (b == CH_PCT) begin
							if (last) begin
								step.ent[n] = mk(k, 1'b1, CH_PCT, 1'b0);
								n = n + 2'd1;
							end else begin
								esc = ESC_HI;
							end
						end else if (ph == PH_PATH && b == CH_QUEST) begin
							step.ent[n] = mk(k, 1'b0, 8'd0, 1'b1);
							n = n + 2'd1;
							ph = PH_QKEY;
						end else if (ph != PH_PATH && b == CH_EQ) begin
							step.ent[n] = mk(k, 1'b0, 8'd0, 1'b1);
							n = n + 2'd1;
							ph = PH_QVAL;
						end else if (ph != PH_PATH && b == CH_AMP) begin
							step.ent[n] = mk(k, 1'b0, 8'd0, 1'b1);
							n = n + 2'd1;
							ph = PH_QKEY;
						end else begin
							step.ent[n] = mk(k, 1'b1, b, 1'b0);
							n = n + 2'd1;
						end
					end
				end
				PH_PROTO: begin
					if (b == CH_LF) begin
						step.ent[n] = mk(KIND_PROTO, 1'b0, 8'd0, 1'b1);
						n = n + 2'd1;
						ph = PH_HKEY;
						ls = 1'b1;
					end else if (!bws) begin
						step.ent[n] = mk(KIND_PROTO, 1'b1, b, 1'b0);
						n = n + 2'd1;
					end
				end
				PH_HKEY: begin
					if (ls && crlf) begin
						// blank line
						ls = 1'b0;
						ph = PH_HEND;
					end else begin
						ls = 1'b0;
						if (b == CH_COLON) begin
							step.ent[n] = mk(KIND_HKEY, 1'b0, 8'd0, 1'b1);
							n = n + 2'd1;
							ph = PH_HGAP;
						end else begin
							step.ent[n] = mk(KIND_HKEY, 1'b1, b, 1'b0);
							n = n + 2'd1;
						end
					end
				end
				PH_HVAL: begin
					if (crlf) begin
						step.ent[n] = mk(KIND_HVAL, 1'b0, 8'd0, 1'b1);
						n = n + 2'd1;
						if (b == CH_CR) begin
							ph = PH_HEOL;
						end else begin
							ph = PH_HKEY;
							ls = 1'b1;
						end
					end else begin
						step.ent[n] = mk(KIND_HVAL, 1'b1, b, 1'b0);
						n = n + 2'd1;
					end
				end
				PH_BODY: begin
					step.ent[n] = mk(KIND_BODY, 1'b1, b, 1'b0);
					n = n + 2'd1;
				end
				default: begin
					if (bws) begin
						step.ent[n] = mk(KIND_VERB, 1'b0, 8'd0, 1'b1);
						n = n + 2'd1;
						ph = PH_GAP;
					end else begin
						step.ent[n] = mk(KIND_VERB, 1'b1, b, 1'b0);
						n = n + 2'd1;
						ph = PH_VERB;
					end
				end
			endcase
		end

		if (last) begin
			case (ph)
				PH_PATH:  fin_kind = KIND_PATH;
				PH_QKEY:  fin_kind = KIND_QKEY;
				PH_QVAL:  fin_kind = KIND_QVAL;
				PH_PROTO: fin_kind = KIND_PROTO;
				PH_HKEY: begin
					fin_kind = KIND_HKEY;
					fin_open = !ls;
				end
				PH_HVAL:  fin_kind = KIND_HVAL;
				PH_BODY:  fin_kind = KIND_BODY;
				PH_GAP, PH_HGAP, PH_HEOL, PH_HEND: fin_open = 1'b0;
				default:  fin_kind = KIND_VERB;
			endcase
			t = fin_open ? mk(fin_kind, 1'b0, 8'd0, 1'b1) : '0;
			t.request_end = 1'b1;
			step.ent[n] = t;
			n = n + 2'd1;
			// back to reset for the next request
			ph   = PH_VERB;
			esc  = ESC_IDLE;
			held = 8'd0;
			ls   = 1'b0;
		end
		step.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VERB;
			esc_q   <= ESC_IDLE;
			held_q  <= 8'd0;
			ls_q    <= 1'b0;
		end else if (adv) begin
			phase_q <= ph;
			esc_q   <= esc;
			held_q  <= held;
			ls_q    <= ls;
		end
	end

endmodule

@@ rtl/core/htok_tok_fifo.sv @@
module htok_tok_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  htok_pkg::step_t step,
	input  logic           pop,
	output htok_pkg::tok_t head,
	output logic [2:0]     level
);
	import htok_pkg::*;

	localparam int unsigned DEPTH = 4;

	tok_t       mem_q [DEPTH];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic [1:0] n_push;

	assign n_push = push ? step.cnt : 2'd0;
	assign head   = mem_q[rd_q];
	assign level  = cnt_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < STEP_MAX; i++) begin
			if (2'(i) < n_push) mem_q[wr_q + 2'(i)] <= step.ent[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + n_push;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, n_push} - {2'd0, pop};
		end
	end

endmodule

@@ rtl/core/http_request_tokenizer_core.sv @@
// channel | direction | payload          | handshake
// --------+-----------+------------------+-----------------------------
// req     | in        | htok_pkg::req_t  | req_valid / req_stall
// tok     | out       | htok_pkg::tok_t  | tok_valid / tok_stall
//
// One request byte is taken per cycle while req_stall is low; it waits in
// the input register until the parser advances and writes its tokens to
// the queue. A byte makes zero to three tokens; the queue drains one token
// per cycle while tok_stall is low, so the byte rate holds at one per cycle
// while no byte makes more than one token. req_stall rises when the input
// register is full and the queue holds two or more tokens. Reset (arst_n
// low) returns the parser to the verb phase and empties the queue.
module http_request_tokenizer_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  htok_pkg::req_t req,
	output logic           tok_valid,
	input  logic           tok_stall,
	output htok_pkg::tok_t tok
);
	import htok_pkg::*;

	// input register stage
	logic  valid_s1;
	req_t  req_s1;

	// parser and queue
	step_t      step;
	logic       adv;
	logic [2:0] level;
	logic       pop;

	// The parser may write up to three tokens; a queue of four with at most
	// one token left always has room.
	assign adv       = valid_s1 && (level < 3'd2);
	assign req_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) req_s1 <= req;
	end

	// byte decode and parse state
	htok_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_s1),
		.adv    (adv),
		.step   (step)
	);

	// token queue, also the output register
	assign pop       = tok_valid && !tok_stall;
	assign tok_valid = (level != 3'd0);

	htok_tok_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv),
		.step   (step),
		.pop    (pop),
		.head   (tok),
		.level  (level)
	);

	// queue never overfills
	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		level <= 3'd4)
		else $error("token queue overflow");

	// the last byte of a request always closes with a request_end token
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_s1.last_byte |->
			(step.cnt == 2'd1 && step.ent[0].request_end) ||
			(step.cnt == 2'd2 && step.ent[1].request_end) ||
			(step.cnt == 2'd3 && step.ent[2].request_end))
		else $error("last byte without request_end");

	// three tokens from one byte only when the byte ends the request
	a_three_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && step.cnt == 2'd3 |-> req_s1.last_byte)
		else $error("three tokens from a middle byte");

	// a push never lands while the queue lacks room for it
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> level <= 3'd4 && $past(level) <= 3'd1)
		else $error("push without room");

endmodule

@@ verif/htok_checker.sv @@
module htok_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  htok_pkg::req_t req,
	input  logic           tok_valid,
	input  logic           tok_stall,
	input  htok_pkg::tok_t tok,
	output int             mismatch_count,
	output int             tokens_owed
);
	import htok_pkg::*;

	// parser state mirrored from the block
	phase_t     phase;
	logic [1:0] esc_step;
	logic [7:0] hi_digit;
	logic       fresh_line;

	tok_t owed_q[$];
	tok_t want_tok;

	function automatic logic is_space(input logic [7:0] b);
		return b == CH_SP || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic logic is_eol(input logic [7:0] b);
		return b == CH_CR || b == CH_LF;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] d);
		logic [7:0] v;
		v = 8'h00;
		if (d >= 8'h61 && d <= 8'h66) begin
			v = d - 8'h61 + 8'd10;
		end else if (d >= 8'h41 && d <= 8'h46) begin
			v = d - 8'h41 + 8'd10;
		end else if (d >= 8'h30 && d <= 8'h39) begin
			v = d - 8'h30;
		end else begin
			return 5'h00;
		end
		return {1'b1, v[3:0]};
	endfunction

	// bad high digit gives a '?' base, bad low digit adds nothing
	function automatic logic [7:0] unescape(input logic [7:0] hi, input logic [7:0] lo);
		logic [4:0] h;
		logic [4:0] l;
		logic [7:0] acc;
		h = hex_digit(hi);
		l = hex_digit(lo);
		acc = h[4] ? {h[3:0], 4'h0} : CH_QUEST;
		if (l[4])
			acc = acc + {4'h0, l[3:0]};
		return acc;
	endfunction

	function automatic logic [2:0] url_kind();
		if (phase == PH_PATH)
			return KIND_PATH;
		if (phase == PH_QKEY)
			return KIND_QKEY;
		return KIND_QVAL;
	endfunction

	task automatic clear_state();
		phase = PH_VERB;
		esc_step = ESC_IDLE;
		hi_digit = 8'h00;
		fresh_line = 1'b0;
	endtask

	task automatic owe(input logic [2:0] kind, input logic has, input logic [7:0] ch,
			input logic fend);
		tok_t t;
		t.field_kind = kind;
		t.has_char = has;
		t.char_out = ch;
		t.field_end = fend;
		t.request_end = 1'b0;
		owed_q.push_back(t);
	endtask

	task automatic url_step(input logic [7:0] b, input logic last);
		logic [2:0] k;
		k = url_kind();
		if (esc_step == ESC_HI) begin
			if (!last) begin
				hi_digit = b;
				esc_step = ESC_LO;
				return;
			end
			// cut-off escape: literal '%', then the byte as usual
			owe(k, 1'b1, CH_PCT, 1'b0);
			esc_step = ESC_IDLE;
		end else if (esc_step != ESC_IDLE) begin
			owe(k, 1'b1, unescape(hi_digit, b), 1'b0);
			esc_step = ESC_IDLE;
			return;
		end
		if (is_space(b)) begin
			owe(k, 1'b0, 8'h00, 1'b1);
			phase = PH_PROTO;
		end else if (b == CH_PCT) begin
			if (last)
				owe(k, 1'b1, CH_PCT, 1'b0);
			else
				esc_step = ESC_HI;
		end else if (phase == PH_PATH && b == CH_QUEST) begin
			owe(k, 1'b0, 8'h00, 1'b1);
			phase = PH_QKEY;
		end else if (phase != PH_PATH && b == CH_EQ) begin
			owe(k, 1'b0, 8'h00, 1'b1);
			phase = PH_QVAL;
		end else if (phase != PH_PATH && b == CH_AMP) begin
			owe(k, 1'b0, 8'h00, 1'b1);
			phase = PH_QKEY;
		end else begin
			owe(k, 1'b1, b, 1'b0);
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		logic again;
		for (int pass = 0; pass < 3; pass++) begin
			again = 1'b0;
			case (phase)
			PH_GAP: begin
				if (!is_space(b)) begin
					phase = PH_PATH;
					again = 1'b1;
				end
			end
			PH_PATH, PH_QKEY, PH_QVAL: url_step(b, last);
			PH_PROTO: begin
				if (b == CH_LF) begin
					owe(KIND_PROTO, 1'b0, 8'h00, 1'b1);
					phase = PH_HKEY;
					fresh_line = 1'b1;
				end else if (!is_space(b)) begin
					owe(KIND_PROTO, 1'b1, b, 1'b0);
				end
			end
			PH_HKEY: begin
				if (fresh_line && is_eol(b)) begin
					fresh_line = 1'b0;
					phase = PH_HEND;
				end else begin
					fresh_line = 1'b0;
					if (b == CH_COLON) begin
						owe(KIND_HKEY, 1'b0, 8'h00, 1'b1);
						phase = PH_HGAP;
					end else begin
						owe(KIND_HKEY, 1'b1, b, 1'b0);
					end
				end
			end
			PH_HGAP: begin
				if (!is_space(b)) begin
					phase = PH_HVAL;
					again = 1'b1;
				end
			end
			PH_HVAL: begin
				if (is_eol(b)) begin
					owe(KIND_HVAL, 1'b0, 8'h00, 1'b1);
					if (b == CH_CR) begin
						phase = PH_HEOL;
					end else begin
						phase = PH_HKEY;
						fresh_line = 1'b1;
					end
				end else begin
					owe(KIND_HVAL, 1'b1, b, 1'b0);
				end
			end
			PH_HEOL: begin
				phase = PH_HKEY;
				fresh_line = 1'b1;
				again = (b != CH_LF);
			end
			PH_HEND: begin
				if (!is_eol(b)) begin
					phase = PH_BODY;
					again = 1'b1;
				end
			end
			PH_BODY: owe(KIND_BODY, 1'b1, b, 1'b0);
			default: begin
				phase = PH_VERB;
				if (is_space(b)) begin
					owe(KIND_VERB, 1'b0, 8'h00, 1'b1);
					phase = PH_GAP;
				end else begin
					owe(KIND_VERB, 1'b1, b, 1'b0);
				end
			end
			endcase
			if (!again)
				break;
		end
	endtask

	// tokens owed for one accepted request byte
	task automatic predict_tokens(input req_t r);
		logic [2:0] k;
		logic       closes;
		tok_t       t;
		parse_byte(r.byte_in, r.last_byte);
		if (r.last_byte) begin
			k = KIND_VERB;
			closes = 1'b1;
			case (phase)
			PH_PATH, PH_QKEY, PH_QVAL: k = url_kind();
			PH_PROTO: k = KIND_PROTO;
			PH_HKEY: begin
				k = KIND_HKEY;
				closes = !fresh_line;
			end
			PH_HVAL: k = KIND_HVAL;
			PH_BODY: k = KIND_BODY;
			PH_GAP, PH_HGAP, PH_HEOL, PH_HEND: closes = 1'b0;
			default: k = KIND_VERB;
			endcase
			if (closes)
				owe(k, 1'b0, 8'h00, 1'b1);
			else
				owe(KIND_VERB, 1'b0, 8'h00, 1'b0);
			t = owed_q.pop_back();
			t.request_end = 1'b1;
			owed_q.push_back(t);
			clear_state();
		end
	endtask

	task automatic report_mismatch(input string what, input tok_t got, input tok_t want);
		$display("checker: %s: got kind %0d has %0b ch %02h end %0b rend %0b, want kind %0d has %0b ch %02h end %0b rend %0b",
			what, got.field_kind, got.has_char, got.char_out, got.field_end,
			got.request_end, want.field_kind, want.has_char, want.char_out,
			want.field_end, want.request_end);
		mismatch_count = mismatch_count + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			owed_q.delete();
			mismatch_count = 0;
			tokens_owed <= 0;
		end else begin
			if (tok_valid && !tok_stall) begin
				if (owed_q.size() == 0) begin
					report_mismatch("token with nothing owed", tok, '0);
				end else begin
					want_tok = owed_q.pop_front();
					if (tok.field_kind !== want_tok.field_kind
							|| tok.has_char !== want_tok.has_char
							|| tok.char_out !== want_tok.char_out
							|| tok.field_end !== want_tok.field_end
							|| tok.request_end !== want_tok.request_end)
						report_mismatch("token mismatch", tok, want_tok);
				end
			end
			if (req_valid && !req_stall)
				predict_tokens(req);
			tokens_owed <= owed_q.size();
		end
	end

endmodule

@@ verif/tb.sv @@
module tb;
	import htok_pkg::*;

	// cycles with no accepted request or token before the run is declared hung;
	// the slowest legal gap is a send pause plus a stall burst plus the pipeline,
	// so this is far over
	localparam int IDLE_LIMIT   = 1000;
	// random request bytes after the directed part
	localparam int RANDOM_ITEMS = 270;
	// the last stretch of the run goes without idling on either side
	localparam int CALM_TAIL    = 50;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic tok_valid;
	logic tok_stall = 1'b0;
	tok_t tok;

	int mismatch_count;
	int tokens_owed;

	int   bytes_sent  = 0;
	int   stall_left  = 0;
	int   idle_cycles = 0;
	logic calm        = 1'b0;

	// bytes of the request being built
	logic [7:0] req_bytes[$];

	http_request_tokenizer_core dut (.*);

	htok_checker chk (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// Receiver: stall in bursts independent of tok_valid, so stalls land on
	// every phase of the token queue.
	always @(posedge clk) begin
		if (calm || !arst_n) begin
			tok_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			tok_stall <= 1'b1;
			stall_left <= $urandom_range(1, 7) - 1;
		end else begin
			tok_stall <= 1'b0;
		end
	end

	// Watchdog: any accepted request or token restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (tok_valid && !tok_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Present one byte and hold it until taken. Valid stays up into the next
	// byte unless an idle burst follows.
	task automatic send_byte(input logic [7:0] b, input logic last);
		req_valid <= 1'b1;
		req <= {b, last};
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		bytes_sent++;
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7))
				@(posedge clk);
		end
	endtask

	// Send the built request; its final byte carries last_byte.
	task automatic send_request();
		foreach (req_bytes[i])
			send_byte(req_bytes[i], i == req_bytes.size() - 1);
		req_bytes.delete();
	endtask

	// Hold the sender off until every owed token has come out. The first edge
	// is waited so the count includes the byte taken at the current edge.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (tokens_owed != 0);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			req_bytes.push_back(s[i]);
	endtask

	// Path or query text: mostly plain characters, some good escapes, and some
	// escapes whose digits are arbitrary bytes (bad hex, white space, delimiters).
	task automatic add_url_text(input int n);
		string hexch;
		string plain;
		int    r;
		hexch = "0123456789abcdefABCDEF";
		plain = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~/";
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r < 2) begin
				req_bytes.push_back(CH_PCT);
				req_bytes.push_back(hexch[$urandom_range(0, hexch.len() - 1)]);
				req_bytes.push_back(hexch[$urandom_range(0, hexch.len() - 1)]);
			end else if (r == 2) begin
				req_bytes.push_back(CH_PCT);
				req_bytes.push_back(8'($urandom_range(0, 255)));
				req_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				req_bytes.push_back(plain[$urandom_range(0, plain.len() - 1)]);
			end
		end
	endtask

	// Mostly a well-formed request with random content, sometimes cut short;
	// the rest is raw noise.
	task automatic build_request();
		int parts;
		int keep;
		int eol;
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 12))
				req_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(1, 4))
			req_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
		// separator: usually space or tab, now and then another white space
		repeat ($urandom_range(1, 2))
			req_bytes.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(8'h0B, 8'h0C))
				: ($urandom_range(0, 1) ? CH_SP : CH_TAB));
		req_bytes.push_back(8'h2F);
		add_url_text($urandom_range(0, 4));
		if ($urandom_range(0, 2) != 0) begin
			req_bytes.push_back(CH_QUEST);
			parts = $urandom_range(1, 4);
			for (int i = 0; i < parts; i++) begin
				if (i != 0)
					req_bytes.push_back($urandom_range(0, 1) ? CH_EQ : CH_AMP);
				add_url_text($urandom_range(0, 3));
			end
		end
		req_bytes.push_back(CH_SP);
		add_text("H/1");
		if ($urandom_range(0, 1))
			req_bytes.push_back(CH_CR);
		req_bytes.push_back(CH_LF);
		repeat ($urandom_range(0, 2)) begin
			repeat ($urandom_range(1, 4))
				req_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
			req_bytes.push_back(CH_COLON);
			repeat ($urandom_range(0, 2))
				req_bytes.push_back(CH_SP);
			repeat ($urandom_range(1, 4))
				req_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
			// line end: CR/LF, bare LF, or a CR standing alone
			eol = $urandom_range(0, 2);
			if (eol != 1)
				req_bytes.push_back(CH_CR);
			if (eol != 2)
				req_bytes.push_back(CH_LF);
		end
		if ($urandom_range(0, 1))
			req_bytes.push_back(CH_CR);
		req_bytes.push_back(CH_LF);
		repeat ($urandom_range(0, 6))
			req_bytes.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) == 0) begin
			keep = $urandom_range(1, req_bytes.size());
			req_bytes = req_bytes[0:keep-1];
		end
	endtask

	initial begin
		int random_end;

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed requests ---
		// lone white space: verb ends, then an empty closing token
		req_bytes.push_back(CH_SP);
		send_request();
		// '%' with only one byte left: literal '%' then the digit as a char
		add_text("G /%4");
		send_request();
		// bad high and low digits (base '?', nothing added), a zero byte as
		// digit, then a '%' that is the final byte of the request
		add_text("G /%g");
		req_bytes.push_back(8'h00);
		add_text("?%");
		send_request();
		// header value ended by a CR on its own, then CR/LF as blank line,
		// body byte 0xFF closing the request
		add_text("x / P\nK:v");
		req_bytes.push_back(CH_CR);
		req_bytes.push_back(CH_CR);
		req_bytes.push_back(CH_LF);
		req_bytes.push_back(8'hFF);
		send_request();

		// sender pauses until every owed token is out
		wait_drained();

		// --- random requests ---
		random_end = bytes_sent + RANDOM_ITEMS;
		while (bytes_sent < random_end) begin
			if (!calm && bytes_sent >= random_end - CALM_TAIL)
				calm <= 1'b1;
			build_request();
			send_request();
			if (!calm && $urandom_range(0, 5) == 0)
				wait_drained();
		end

		// drain, then give the pipeline time to show any stray token
		wait_drained();
		repeat (10)
			@(posedge clk);

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/htok_pkg.sv
rtl/core/htok_parser.sv
rtl/core/htok_tok_fifo.sv
rtl/core/http_request_tokenizer_core.sv
verif/htok_checker.sv
verif/tb.sv
